/* hdl/btmx_pkg.sv */
// ----------------------------------------------------------------------------
// btmx_pkg
// Shared types and constants for the binary trie maximum-XOR block.
// ----------------------------------------------------------------------------
`default_nettype none

package btmx_pkg;

	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic alloc;
		logic hit;
		logic stop;
	} step_ctl_t;

endpackage

`default_nettype wire

/* hdl/binary_trie_max_xor.sv */
// ----------------------------------------------------------------------------
// binary_trie_max_xor
// Binary trie of VALUE_BITS-bit values with insert and maximum-XOR query.
// ----------------------------------------------------------------------------
// One item is taken at a time. An insert or query walks the trie one level
// after another, because each trie level needs one dependent read of the node
// memory and the level step unit is shared by all levels. An insert dropped
// for a full pool and a query on an empty trie skip the walk. The next item
// may transfer in while the previous result still waits at the output. A
// node's links are written when its first child is allocated, nodes allocated
// by the insert in progress read as empty, and the root links sit in
// registers, so no clearing pass is needed after reset.
`default_nettype none

module binary_trie_max_xor #(
	parameter int VALUE_BITS = 32,
	parameter int NODE_COUNT = 4096
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             req_valid,
	output logic                                  req_stall,
	input  wire logic                             cmd,
	input  wire logic [btmx_pkg::VALUE_W-1:0]     value,
	output logic                                  rsp_valid,
	input  wire logic                             rsp_stall,
	output logic      [btmx_pkg::VALUE_W-1:0]     max_xor,
	output btmx_pkg::status_t                     status
);

	localparam int NODE_W = $clog2(NODE_COUNT);
	localparam int CNT_W  = $clog2(NODE_COUNT + 1);
	localparam int IDX_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
	localparam int LINK_W = 2 * NODE_W;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t                       state_q;
	logic                         cmd_q;
	logic [VALUE_BITS-1:0]        value_q;
	logic [VALUE_BITS-1:0]        acc_q;
	logic [IDX_W-1:0]             lvl_q;
	logic [NODE_W-1:0]            node_q;
	logic                         at_root_q;
	logic                         fresh_q;
	logic [CNT_W-1:0]             nf_q;
	logic [LINK_W-1:0]            root_q;
	btmx_pkg::status_t            res_status_q;
	logic                         rsp_valid_q;
	logic [btmx_pkg::VALUE_W-1:0] max_xor_q;
	btmx_pkg::status_t            status_q;

	logic                         accept;
	logic                         is_query;
	logic                         pool_full;
	logic                         root_empty;
	logic                         early_out;
	logic [LINK_W-1:0]            cur_links;
	logic [LINK_W-1:0]            ram_rdata;
	logic [NODE_W-1:0]            next_node;
	logic [LINK_W-1:0]            new_links;
	btmx_pkg::step_ctl_t          ctl;
	logic                         walk_end;
	logic                         ram_we;
	logic                         out_free;
	logic                         out_load;

	assign req_stall  = (state_q != S_IDLE);
	assign accept     = req_valid && (state_q == S_IDLE);
	assign is_query   = (cmd == btmx_pkg::CMD_QUERY);
	assign pool_full  = (CNT_W+1)'(NODE_COUNT) <
	                    ({1'b0, nf_q} + (CNT_W+1)'(VALUE_BITS));
	assign root_empty = (root_q == '0);
	assign early_out  = is_query ? root_empty : pool_full;

	assign cur_links = at_root_q ? root_q : (fresh_q ? '0 : ram_rdata);
	assign walk_end  = (state_q == S_WALK) && ((lvl_q == '0) || ctl.stop);
	assign ram_we    = (state_q == S_WALK) && ctl.alloc && !at_root_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign out_load  = (state_q == S_DONE) && out_free;

	btmx_step #(
		.NODE_W(NODE_W)
	) u_step (
		.is_query (cmd_q == btmx_pkg::CMD_QUERY),
		.bit_in   (value_q[lvl_q]),
		.links    (cur_links),
		.free_node(nf_q[NODE_W-1:0]),
		.next_node(next_node),
		.new_links(new_links),
		.ctl      (ctl)
	);

	btmx_ram #(
		.WIDTH(LINK_W),
		.DEPTH(NODE_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(node_q),
		.wdata(new_links),
		.raddr(next_node),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			nf_q        <= CNT_W'(1);
			root_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= early_out ? S_DONE : S_WALK;
					end
				end
				S_WALK: begin
					if (ctl.alloc) begin
						nf_q <= nf_q + CNT_W'(1);
						if (at_root_q) begin
							root_q <= new_links;
						end
					end
					if (walk_end) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd;
			value_q   <= VALUE_BITS'(value);
			acc_q     <= '0;
			lvl_q     <= IDX_W'(VALUE_BITS - 1);
			node_q    <= '0;
			at_root_q <= 1'b1;
			fresh_q   <= 1'b0;
			if (!early_out) begin
				res_status_q <= btmx_pkg::ST_OK;
			end else if (is_query) begin
				res_status_q <= btmx_pkg::ST_EMPTY;
			end else begin
				res_status_q <= btmx_pkg::ST_FULL;
			end
		end
		if (state_q == S_WALK) begin
			lvl_q     <= lvl_q - IDX_W'(1);
			node_q    <= next_node;
			at_root_q <= 1'b0;
			if (ctl.alloc) begin
				fresh_q <= 1'b1;
			end
			if (ctl.hit) begin
				acc_q[lvl_q] <= 1'b1;
			end
		end
		if (out_load) begin
			max_xor_q <= btmx_pkg::VALUE_W'(acc_q);
			status_q  <= res_status_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign max_xor   = max_xor_q;
	assign status    = status_q;

endmodule

`default_nettype wire

/* hdl/btmx_ram.sv */
// ----------------------------------------------------------------------------
// btmx_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module btmx_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* hdl/btmx_step.sv */
// ----------------------------------------------------------------------------
// btmx_step
// One trie level: picks the child to follow and decides on a node allocation.
// ----------------------------------------------------------------------------
`default_nettype none

module btmx_step #(
	parameter int NODE_W = 12
) (
	input  wire logic                       is_query,
	input  wire logic                       bit_in,
	input  wire logic [2*NODE_W-1:0]        links,
	input  wire logic [NODE_W-1:0]          free_node,
	output logic      [NODE_W-1:0]          next_node,
	output logic      [2*NODE_W-1:0]        new_links,
	output btmx_pkg::step_ctl_t             ctl
);

	logic [NODE_W-1:0] child0;
	logic [NODE_W-1:0] child1;
	logic [NODE_W-1:0] same;
	logic [NODE_W-1:0] flip;

	assign child0 = links[NODE_W-1:0];
	assign child1 = links[2*NODE_W-1:NODE_W];
	assign same   = bit_in ? child1 : child0;
	assign flip   = bit_in ? child0 : child1;

	always_comb begin
		ctl       = '0;
		next_node = same;
		new_links = links;
		if (is_query) begin
			if (flip != '0) begin
				ctl.hit   = 1'b1;
				next_node = flip;
			end else if (same == '0) begin
				ctl.stop = 1'b1;
			end
		end else if (same == '0) begin
			ctl.alloc = 1'b1;
			next_node = free_node;
			if (bit_in) begin
				new_links[2*NODE_W-1:NODE_W] = free_node;
			end else begin
				new_links[NODE_W-1:0] = free_node;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/btmx_chk.sv */
// ----------------------------------------------------------------------------
// btmx_chk
// Port-level checks for the binary trie maximum-XOR block.
// ----------------------------------------------------------------------------
`default_nettype none

module btmx_chk (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         req_valid,
	input wire logic                         req_stall,
	input wire logic                         rsp_valid,
	input wire logic                         rsp_stall,
	input wire logic [btmx_pkg::VALUE_W-1:0] max_xor,
	input wire btmx_pkg::status_t            status
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("block took a transfer without going busy");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != btmx_pkg::ST_OK) |-> (max_xor == '0))
		else $error("failed item returned a nonzero result");

	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result appeared without an item in progress");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(max_xor) && $stable(status))
		else $error("stalled result changed");

endmodule

bind binary_trie_max_xor btmx_chk u_btmx_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.max_xor  (max_xor),
	.status   (status)
);

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the binary trie maximum-XOR block. A table of
// directed transfers covers the empty trie, the value extremes and duplicate
// inserts. Random inserts and queries follow and drive the node pool to its
// full state. Results are checked against the table or a local model of the
// trie; past the table, items meet changing sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	localparam int NODE_N    = 4096;
	localparam int DIR_N     = 18;
	localparam int RAND_N    = 1300;
	localparam int FILL_N    = 200;
	localparam int CHUNK_N   = 100;
	localparam int DRAIN_CYC = 40;

	typedef struct packed {
		logic [btmx_pkg::VALUE_W-1:0] xor_val;
		btmx_pkg::status_t            st;
	} answer_t;

	typedef struct packed {
		logic                         cmd;
		logic [btmx_pkg::VALUE_W-1:0] value;
		logic                         typed;
		logic [btmx_pkg::VALUE_W-1:0] xor_val;
		btmx_pkg::status_t            st;
	} dir_row_t;

	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		'{btmx_pkg::CMD_QUERY,  32'h0000_0000, 1'b1, 32'h0000_0000, btmx_pkg::ST_EMPTY},
		'{btmx_pkg::CMD_QUERY,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, btmx_pkg::ST_EMPTY},
		'{btmx_pkg::CMD_INSERT, 32'h0000_0000, 1'b1, 32'h0000_0000, btmx_pkg::ST_OK},
		'{btmx_pkg::CMD_QUERY,  32'h0000_0000, 1'b1, 32'h0000_0000, btmx_pkg::ST_OK},
		'{btmx_pkg::CMD_QUERY,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, btmx_pkg::ST_OK},
		'{btmx_pkg::CMD_INSERT, 32'h0000_0000, 1'b1, 32'h0000_0000, btmx_pkg::ST_OK},
		'{btmx_pkg::CMD_INSERT, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, btmx_pkg::ST_OK},
		'{btmx_pkg::CMD_QUERY,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF, btmx_pkg::ST_OK},
		'{btmx_pkg::CMD_QUERY,  32'h8000_0000, 1'b0, 32'h0000_0000, btmx_pkg::ST_OK},
		'{btmx_pkg::CMD_INSERT, 32'h8000_0000, 1'b1, 32'h0000_0000, btmx_pkg::ST_OK},
		'{btmx_pkg::CMD_INSERT, 32'h0000_0001, 1'b1, 32'h0000_0000, btmx_pkg::ST_OK},
		'{btmx_pkg::CMD_QUERY,  32'h7FFF_FFFE, 1'b0, 32'h0000_0000, btmx_pkg::ST_OK},
		'{btmx_pkg::CMD_QUERY,  32'h5555_5555, 1'b0, 32'h0000_0000, btmx_pkg::ST_OK},
		'{btmx_pkg::CMD_INSERT, 32'hAAAA_AAAA, 1'b1, 32'h0000_0000, btmx_pkg::ST_OK},
		'{btmx_pkg::CMD_QUERY,  32'h5555_5555, 1'b1, 32'hFFFF_FFFF, btmx_pkg::ST_OK},
		'{btmx_pkg::CMD_QUERY,  32'h1234_5678, 1'b0, 32'h0000_0000, btmx_pkg::ST_OK},
		'{btmx_pkg::CMD_INSERT, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, btmx_pkg::ST_OK},
		'{btmx_pkg::CMD_QUERY,  32'h8000_0000, 1'b0, 32'h0000_0000, btmx_pkg::ST_OK}
	};

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         req_valid = 1'b0;
	logic                         req_stall;
	logic                         cmd       = btmx_pkg::CMD_INSERT;
	logic [btmx_pkg::VALUE_W-1:0] value     = '0;
	logic                         rsp_valid;
	logic                         rsp_stall = 1'b0;
	logic [btmx_pkg::VALUE_W-1:0] max_xor;
	btmx_pkg::status_t            status;

	logic [12:0]                  trie_kid [NODE_N][2];
	int unsigned                  free_ptr;
	answer_t                      answer_q [$];
	logic [btmx_pkg::VALUE_W-1:0] stored_vals [$];
	logic [btmx_pkg::VALUE_W-1:0] prefixes [8];
	int                           fail_count = 0;
	int                           send_idle_pct = 0;
	int                           recv_stall_pct = 0;
	int                           hold_reqs = 0;
	int                           hold_seen = 0;
	int                           hold_left = 0;

	binary_trie_max_xor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.value     (value),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.max_xor   (max_xor),
		.status    (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic answer_t trie_predict(input logic c,
			input logic [btmx_pkg::VALUE_W-1:0] v);
		answer_t     ans;
		logic [12:0] node;
		logic [12:0] nxt;
		logic        b;
		ans.xor_val = '0;
		ans.st = btmx_pkg::ST_OK;
		node = '0;
		if (c == btmx_pkg::CMD_INSERT) begin
			if (free_ptr + btmx_pkg::VALUE_W > NODE_N) begin
				ans.st = btmx_pkg::ST_FULL;
				return ans;
			end
			for (int lvl = btmx_pkg::VALUE_W - 1; lvl >= 0; lvl--) begin
				b = v[lvl];
				nxt = trie_kid[node][b];
				if (nxt == 0) begin
					nxt = free_ptr[12:0];
					free_ptr++;
					trie_kid[nxt][0] = '0;
					trie_kid[nxt][1] = '0;
					trie_kid[node][b] = nxt;
				end
				node = nxt;
			end
			stored_vals.insert(stored_vals.size(), v);
		end else begin
			if (trie_kid[0][0] == 0 && trie_kid[0][1] == 0) begin
				ans.st = btmx_pkg::ST_EMPTY;
				return ans;
			end
			for (int lvl = btmx_pkg::VALUE_W - 1; lvl >= 0; lvl--) begin
				b = v[lvl];
				if (trie_kid[node][!b] != 0) begin
					ans.xor_val[lvl] = 1'b1;
					node = trie_kid[node][!b];
				end else if (trie_kid[node][b] != 0) begin
					node = trie_kid[node][b];
				end else begin
					break;
				end
			end
		end
		return ans;
	endfunction

	task automatic offer_item(input logic c, input logic [btmx_pkg::VALUE_W-1:0] v);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_valid <= 1'b1;
		cmd <= c;
		value <= v;
		@(posedge clk);
		while (req_stall !== 1'b0) @(posedge clk);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (answer_q.size() != 0) @(posedge clk);
	endtask

	task automatic send_predicted(input logic c, input logic [btmx_pkg::VALUE_W-1:0] v,
			output btmx_pkg::status_t st);
		answer_t ans;
		offer_item(c, v);
		ans = trie_predict(c, v);
		answer_q.insert(answer_q.size(), ans);
		st = ans.st;
	endtask

	function automatic logic [btmx_pkg::VALUE_W-1:0] near_prefix();
		logic [btmx_pkg::VALUE_W-1:0] mask;
		mask = (32'h1 << $urandom_range(14, 1)) - 1;
		return (prefixes[$urandom_range(7)] & ~mask) | ($urandom() & mask);
	endfunction

	function automatic logic [btmx_pkg::VALUE_W-1:0] insert_value();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10)
			return $urandom();
		if (r < 25 && stored_vals.size() != 0)
			return stored_vals[$urandom_range(stored_vals.size() - 1)];
		return near_prefix();
	endfunction

	function automatic logic [btmx_pkg::VALUE_W-1:0] query_value();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 50)
			return $urandom();
		if (r < 80 || stored_vals.size() == 0)
			return near_prefix();
		return stored_vals[$urandom_range(stored_vals.size() - 1)] ^ $urandom_range(255);
	endfunction

	always @(posedge clk) begin
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_reqs) begin
			hold_seen <= hold_reqs;
			hold_left <= 300;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin : result_check
		answer_t want;
		if (arst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (answer_q.size() == 0) begin
				$error("result transfer with nothing outstanding: max_xor %h status %0d",
					max_xor, status);
				fail_count++;
			end else begin
				want = answer_q.pop_front();
				if (max_xor !== want.xor_val) begin
					$error("max_xor expected %h actual %h", want.xor_val, max_xor);
					fail_count++;
				end
				if (status !== want.st) begin
					$error("status expected %0d actual %0d", want.st, status);
					fail_count++;
				end
			end
		end
	end

	initial begin : stimulus
		answer_t           ans;
		btmx_pkg::status_t st;
		int                mode;
		for (int n = 0; n < NODE_N; n++) begin
			trie_kid[n][0] = '0;
			trie_kid[n][1] = '0;
		end
		free_ptr = 1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++) begin
			offer_item(DIR_ROWS[i].cmd, DIR_ROWS[i].value);
			ans = trie_predict(DIR_ROWS[i].cmd, DIR_ROWS[i].value);
			if (DIR_ROWS[i].typed) begin
				ans.xor_val = DIR_ROWS[i].xor_val;
				ans.st = DIR_ROWS[i].st;
			end
			answer_q.insert(answer_q.size(), ans);
		end
		drain_results();

		foreach (prefixes[k])
			prefixes[k] = $urandom();
		for (int i = 0; i < RAND_N; i++) begin
			if (i % CHUNK_N == 0) begin
				mode = (i / CHUNK_N) % 4;
				send_idle_pct = (mode == 1) ? 55 : (mode == 3) ? 6 : 0;
				recv_stall_pct = (mode == 2) ? 55 : (mode == 3) ? 6 : 0;
				if (i == 2 * CHUNK_N)
					hold_reqs++;
			end
			if ($urandom_range(1) == 0)
				send_predicted(btmx_pkg::CMD_INSERT, insert_value(), st);
			else
				send_predicted(btmx_pkg::CMD_QUERY, query_value(), st);
			if (i % CHUNK_N == CHUNK_N - 1)
				drain_results();
		end

		// Fill the node pool with wide-spread values, then show that a
		// duplicate is refused once fewer than a full path of nodes is free.
		send_idle_pct = 6;
		recv_stall_pct = 6;
		for (int i = 0; i < FILL_N; i++) begin
			send_predicted(btmx_pkg::CMD_INSERT, $urandom(), st);
			if (st == btmx_pkg::ST_FULL)
				break;
		end
		send_predicted(btmx_pkg::CMD_INSERT, stored_vals[0], st);
		for (int i = 0; i < 20; i++)
			send_predicted(btmx_pkg::CMD_QUERY, query_value(), st);

		drain_results();
		repeat (DRAIN_CYC) @(posedge clk);
		if (fail_count == 0 && answer_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

/* filelist.f */
hdl/btmx_pkg.sv
hdl/btmx_ram.sv
hdl/btmx_step.sv
hdl/binary_trie_max_xor.sv
hdl/btmx_chk.sv
tb/tb_top.sv
